[rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
// Each macro samples on the rising edge of clock and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/odi_pkg.sv]
`default_nettype none
package odi_pkg;

   // Field widths of the input and result items.
   localparam int VEL_W   = 16;
   localparam int RATE_W  = 24;
   localparam int DT_W    = 16;
   localparam int POS_W   = 32;
   localparam int HEAD_W  = 16;
   localparam int REQ_W   = 2 * VEL_W + RATE_W + DT_W;
   localparam int RSP_W   = 2 * POS_W + HEAD_W;

   // Internal arithmetic widths.
   localparam int CS_W    = 32;                 // Q2.30 cosine and sine, CORDIC angle
   localparam int PROD_W  = VEL_W + CS_W + 1;   // rotated velocity, Q7.42
   localparam int SCALE_W = PROD_W + DT_W;      // velocity times time, Q58
   localparam int RPROD_W = RATE_W + DT_W;      // turn rate times time
   localparam int DSHIFT  = 42;                 // Q58 down to Q16.16
   localparam int DELTA_W = SCALE_W - DSHIFT;   // position step
   localparam int HSHIFT  = 16;                 // 2^-32 turn down to 2^-16 turn

   // CORDIC constants.
   localparam int ATAN_ENTRIES  = 24;
   localparam int STEP_W        = $clog2(ATAN_ENTRIES);
   localparam int TRIG_STEPS_DEF = 16;
   localparam logic signed [CS_W-1:0] KINV_Q30 = 32'sd652032874;

   // Arctangent of 2^-i in 2^-32 turn units.
   function automatic logic signed [CS_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
      logic signed [CS_W-1:0] val;
      unique case (idx)
         5'd0:    val = 32'sd536870912;
         5'd1:    val = 32'sd316933406;
         5'd2:    val = 32'sd167458907;
         5'd3:    val = 32'sd85004756;
         5'd4:    val = 32'sd42667331;
         5'd5:    val = 32'sd21354465;
         5'd6:    val = 32'sd10679838;
         5'd7:    val = 32'sd5340245;
         5'd8:    val = 32'sd2670163;
         5'd9:    val = 32'sd1335087;
         5'd10:   val = 32'sd667544;
         5'd11:   val = 32'sd333772;
         5'd12:   val = 32'sd166886;
         5'd13:   val = 32'sd83443;
         5'd14:   val = 32'sd41722;
         5'd15:   val = 32'sd20861;
         5'd16:   val = 32'sd10430;
         5'd17:   val = 32'sd5215;
         5'd18:   val = 32'sd2608;
         5'd19:   val = 32'sd1304;
         5'd20:   val = 32'sd652;
         5'd21:   val = 32'sd326;
         5'd22:   val = 32'sd163;
         5'd23:   val = 32'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

[rtl/odi_cordic.sv]
`default_nettype none
module odi_cordic #(
   parameter int TRIG_STEPS = odi_pkg::TRIG_STEPS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [odi_pkg::HEAD_W-1:0]        heading,
   output logic                                   done,
   output logic signed [odi_pkg::CS_W-1:0]        cos_out,
   output logic signed [odi_pkg::CS_W-1:0]        sin_out
);
   import odi_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [CS_W-1:0]   x_ff, x_in;
   logic signed [CS_W-1:0]   y_ff, y_in;
   logic signed [CS_W-1:0]   z_ff, z_in;
   logic signed [CS_W-1:0]   x_sh;
   logic signed [CS_W-1:0]   y_sh;
   logic signed [CS_W-1:0]   atan_val;
   logic                     last_step;
   logic                     swap_half;

   assign last_step = (step_ff == STEP_W'(TRIG_STEPS - 1));
   assign x_sh      = x_ff >>> step_ff;
   assign y_sh      = y_ff >>> step_ff;
   assign atan_val  = atan_turn(step_ff);

   // Headings in the second or third quadrant are turned by half a turn and
   // the start vector is negated, which keeps the residual angle small.
   assign swap_half = heading[HEAD_W-1] ^ heading[HEAD_W-2];

   // One micro-rotation per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = busy_ff && last_step;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = swap_half ? -KINV_Q30 : KINV_Q30;
         y_in    = '0;
         z_in    = {heading[HEAD_W-2], heading[HEAD_W-2:0], {(CS_W-HEAD_W){1'b0}}};
      end else if (busy_ff) begin
         if (!z_ff[CS_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_val;
         end
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = x_ff;
   assign sin_out = y_ff;

endmodule
`default_nettype wire

[rtl/odi_rotate.sv]
`default_nettype none
module odi_rotate (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [odi_pkg::CS_W-1:0]   cos_in,
   input  wire logic signed [odi_pkg::CS_W-1:0]   sin_in,
   input  wire logic signed [odi_pkg::VEL_W-1:0]  vel_x,
   input  wire logic signed [odi_pkg::VEL_W-1:0]  vel_y,
   output logic                                   done,
   output logic signed [odi_pkg::PROD_W-1:0]      prod_x,
   output logic signed [odi_pkg::PROD_W-1:0]      prod_y
);
   import odi_pkg::*;

   localparam int CNT_W = $clog2(VEL_W);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [VEL_W-1:0]          vx_sr_ff, vx_sr_in;
   logic [VEL_W-1:0]          vy_sr_ff, vy_sr_in;
   logic signed [PROD_W-1:0]  c_sh_ff, c_sh_in;
   logic signed [PROD_W-1:0]  s_sh_ff, s_sh_in;
   logic signed [PROD_W-1:0]  acc_x_ff, acc_x_in;
   logic signed [PROD_W-1:0]  acc_y_ff, acc_y_in;
   logic signed [PROD_W-1:0]  term_x;
   logic signed [PROD_W-1:0]  term_y;
   logic                      last_bit;

   assign last_bit = (cnt_ff == CNT_W'(VEL_W - 1));

   // Partial products for the current velocity bits: vx*c - vy*s and vx*s + vy*c.
   assign term_x = (vx_sr_ff[0] ? c_sh_ff : '0) - (vy_sr_ff[0] ? s_sh_ff : '0);
   assign term_y = (vx_sr_ff[0] ? s_sh_ff : '0) + (vy_sr_ff[0] ? c_sh_ff : '0);

   // One bit of each velocity per cycle, least significant first; the sign bit
   // carries negative weight.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = busy_ff && last_bit;
      cnt_in   = cnt_ff;
      vx_sr_in = vx_sr_ff;
      vy_sr_in = vy_sr_ff;
      c_sh_in  = c_sh_ff;
      s_sh_in  = s_sh_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         vx_sr_in = vel_x;
         vy_sr_in = vel_y;
         c_sh_in  = PROD_W'(cos_in);
         s_sh_in  = PROD_W'(sin_in);
         acc_x_in = '0;
         acc_y_in = '0;
      end else if (busy_ff) begin
         acc_x_in = last_bit ? acc_x_ff - term_x : acc_x_ff + term_x;
         acc_y_in = last_bit ? acc_y_ff - term_y : acc_y_ff + term_y;
         vx_sr_in = vx_sr_ff >> 1;
         vy_sr_in = vy_sr_ff >> 1;
         c_sh_in  = c_sh_ff <<< 1;
         s_sh_in  = s_sh_ff <<< 1;
         cnt_in   = cnt_ff + CNT_W'(1);
         if (last_bit) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_sr_ff <= vx_sr_in;
      vy_sr_ff <= vy_sr_in;
      c_sh_ff  <= c_sh_in;
      s_sh_ff  <= s_sh_in;
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
   end

   assign done   = done_ff;
   assign prod_x = acc_x_ff;
   assign prod_y = acc_y_ff;

endmodule
`default_nettype wire

[rtl/odi_scale.sv]
`default_nettype none
module odi_scale (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [odi_pkg::PROD_W-1:0]  prod_x,
   input  wire logic signed [odi_pkg::PROD_W-1:0]  prod_y,
   input  wire logic signed [odi_pkg::RATE_W-1:0]  turn_rate,
   input  wire logic [odi_pkg::DT_W-1:0]           elapsed_time,
   output logic                                    done,
   output logic signed [odi_pkg::DELTA_W-1:0]      delta_x,
   output logic signed [odi_pkg::DELTA_W-1:0]      delta_y,
   output logic [odi_pkg::HEAD_W-1:0]              delta_heading
);
   import odi_pkg::*;

   localparam int CNT_W = $clog2(DT_W);
   // Rounding offsets: half of the last kept bit, added up front.
   localparam logic signed [SCALE_W-1:0] ROUND_POS  = SCALE_W'(1) <<< (DSHIFT - 1);
   localparam logic signed [RPROD_W-1:0] ROUND_HEAD = RPROD_W'(1) <<< (HSHIFT - 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [DT_W-1:0]            dt_sr_ff, dt_sr_in;
   logic signed [SCALE_W-1:0]  px_sh_ff, px_sh_in;
   logic signed [SCALE_W-1:0]  py_sh_ff, py_sh_in;
   logic signed [RPROD_W-1:0]  r_sh_ff, r_sh_in;
   logic signed [SCALE_W-1:0]  acc_x_ff, acc_x_in;
   logic signed [SCALE_W-1:0]  acc_y_ff, acc_y_in;
   logic signed [RPROD_W-1:0]  acc_r_ff, acc_r_in;
   logic                       last_bit;

   assign last_bit = (cnt_ff == CNT_W'(DT_W - 1));

   // One bit of the elapsed time per cycle, least significant first, shared by
   // both position products and the heading product.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = busy_ff && last_bit;
      cnt_in   = cnt_ff;
      dt_sr_in = dt_sr_ff;
      px_sh_in = px_sh_ff;
      py_sh_in = py_sh_ff;
      r_sh_in  = r_sh_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      acc_r_in = acc_r_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         dt_sr_in = elapsed_time;
         px_sh_in = SCALE_W'(prod_x);
         py_sh_in = SCALE_W'(prod_y);
         r_sh_in  = RPROD_W'(turn_rate);
         acc_x_in = ROUND_POS;
         acc_y_in = ROUND_POS;
         acc_r_in = ROUND_HEAD;
      end else if (busy_ff) begin
         if (dt_sr_ff[0]) begin
            acc_x_in = acc_x_ff + px_sh_ff;
            acc_y_in = acc_y_ff + py_sh_ff;
            acc_r_in = acc_r_ff + r_sh_ff;
         end
         dt_sr_in = dt_sr_ff >> 1;
         px_sh_in = px_sh_ff <<< 1;
         py_sh_in = py_sh_ff <<< 1;
         r_sh_in  = r_sh_ff <<< 1;
         cnt_in   = cnt_ff + CNT_W'(1);
         if (last_bit) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_sr_ff <= dt_sr_in;
      px_sh_ff <= px_sh_in;
      py_sh_ff <= py_sh_in;
      r_sh_ff  <= r_sh_in;
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      acc_r_ff <= acc_r_in;
   end

   // Dropping the low bits floors; the offset added at start makes it round.
   assign done          = done_ff;
   assign delta_x       = acc_x_ff[SCALE_W-1:DSHIFT];
   assign delta_y       = acc_y_ff[SCALE_W-1:DSHIFT];
   assign delta_heading = acc_r_ff[HSHIFT+HEAD_W-1:HSHIFT];

endmodule
`default_nettype wire

[rtl/planar_odometry_integrator_top.sv]
// A velocity item is taken when ready and gives no result; the next item may follow at once.
// A tick item runs the TRIG_STEPS CORDIC iterations, then the bit-serial rotation over the
// velocity bits, then the time scaling over the elapsed-time bits, and commits its result.
// The input is ready again with the result, so a tick is not taken while one is in flight.
// A result still held at the output stalls only the commit of the next tick.
// Synchronous active-high reset clears positions, heading and stored velocities.
`default_nettype none
`include "assert_macros.svh"
module planar_odometry_integrator_top #(
   parameter int TRIG_STEPS = odi_pkg::TRIG_STEPS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // velocity_x [15:0], velocity_y [31:16], turn_rate [55:32], elapsed_time [71:56]
   input  wire logic [odi_pkg::REQ_W-1:0]    req_tdata,
   // command [0]
   input  wire logic                         req_tuser,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // position_x [31:0], position_y [63:32], heading_angle [79:64]
   output logic [odi_pkg::RSP_W-1:0]         rsp_tdata
);
   import odi_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TRIG  = 3'd1;
   localparam logic [2:0] ST_ROT   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   localparam logic CMD_SET_VEL = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   logic [2:0]                 state_ff, state_in;
   logic signed [POS_W-1:0]    pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]    pos_y_ff, pos_y_in;
   logic [HEAD_W-1:0]          heading_ff, heading_in;
   logic signed [VEL_W-1:0]    vel_x_ff, vel_x_in;
   logic signed [VEL_W-1:0]    vel_y_ff, vel_y_in;
   logic signed [RATE_W-1:0]   rate_ff, rate_in;
   logic [DT_W-1:0]            dt_ff, dt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;

   logic                       req_accept;
   logic                       vel_accept;
   logic                       tick_start;
   logic                       rsp_load;
   logic                       cordic_done;
   logic                       rot_done;
   logic                       scale_done;
   logic signed [CS_W-1:0]     cos_val;
   logic signed [CS_W-1:0]     sin_val;
   logic signed [PROD_W-1:0]   prod_x;
   logic signed [PROD_W-1:0]   prod_y;
   logic signed [DELTA_W-1:0]  delta_x;
   logic signed [DELTA_W-1:0]  delta_y;
   logic [HEAD_W-1:0]          delta_heading;
   logic signed [POS_W:0]      sum_x;
   logic signed [POS_W:0]      sum_y;
   logic signed [POS_W-1:0]    new_pos_x;
   logic signed [POS_W-1:0]    new_pos_y;
   logic [HEAD_W-1:0]          new_heading;
   logic [RSP_W-1:0]           pose;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign vel_accept = req_accept && (req_tuser == CMD_SET_VEL);
   assign tick_start = req_accept && (req_tuser == CMD_TICK);
   assign rsp_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   odi_cordic #(
      .TRIG_STEPS (TRIG_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (tick_start),
      .heading (heading_ff),
      .done    (cordic_done),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   odi_rotate u_rotate (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_done),
      .cos_in (cos_val),
      .sin_in (sin_val),
      .vel_x  (vel_x_ff),
      .vel_y  (vel_y_ff),
      .done   (rot_done),
      .prod_x (prod_x),
      .prod_y (prod_y)
   );

   odi_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .start         (rot_done),
      .prod_x        (prod_x),
      .prod_y        (prod_y),
      .turn_rate     (rate_ff),
      .elapsed_time  (dt_ff),
      .done          (scale_done),
      .delta_x       (delta_x),
      .delta_y       (delta_y),
      .delta_heading (delta_heading)
   );

   // Saturating position update and wrapping heading update.
   assign sum_x       = (POS_W+1)'(pos_x_ff) + (POS_W+1)'(delta_x);
   assign sum_y       = (POS_W+1)'(pos_y_ff) + (POS_W+1)'(delta_y);
   assign new_pos_x   = (sum_x[POS_W] != sum_x[POS_W-1]) ?
                        (sum_x[POS_W] ? POS_MIN : POS_MAX) : sum_x[POS_W-1:0];
   assign new_pos_y   = (sum_y[POS_W] != sum_y[POS_W-1]) ?
                        (sum_y[POS_W] ? POS_MIN : POS_MAX) : sum_y[POS_W-1:0];
   assign new_heading = heading_ff + delta_heading;

   // Sequencer over the three engines.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (tick_start) begin
                      state_in = ST_TRIG;
                   end
         ST_TRIG:  if (cordic_done) begin
                      state_in = ST_ROT;
                   end
         ST_ROT:   if (rot_done) begin
                      state_in = ST_SCALE;
                   end
         ST_SCALE: if (scale_done) begin
                      state_in = ST_FIN;
                   end
         ST_FIN:   if (rsp_load) begin
                      state_in = ST_IDLE;
                   end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Stored velocities, tick time and accumulated pose.
   always_comb begin
      vel_x_in   = vel_x_ff;
      vel_y_in   = vel_y_ff;
      rate_in    = rate_ff;
      dt_in      = dt_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      heading_in = heading_ff;
      if (vel_accept) begin
         vel_x_in = req_tdata[VEL_W-1:0];
         vel_y_in = req_tdata[2*VEL_W-1:VEL_W];
         rate_in  = req_tdata[2*VEL_W+RATE_W-1:2*VEL_W];
      end
      if (tick_start) begin
         dt_in = req_tdata[REQ_W-1:2*VEL_W+RATE_W];
      end
      if (rsp_load) begin
         pos_x_in   = new_pos_x;
         pos_y_in   = new_pos_y;
         heading_in = new_heading;
      end
   end

   // Output register: holds the result until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {new_heading, new_pos_y, new_pos_x};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         rate_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         rate_ff      <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The whole pose, as one vector for the checks below.
   assign pose = {heading_ff, pos_y_ff, pos_x_ff};

   // A velocity item never moves the pose.
   `ASSERT_NEXT(a_vel_keeps_pose, vel_accept, $stable(pose), "velocity item moved the pose")
   // The heading only changes when a result is committed.
   `ASSERT_NEXT(a_heading_on_load, !rsp_load, $stable(heading_ff), "heading moved with no result")
   // The CORDIC and scaling engines finish only while the sequencer waits for them.
   `ASSERT_IMPLIES(a_cordic_in_trig, cordic_done, state_ff == ST_TRIG, "CORDIC done out of turn")
   `ASSERT_IMPLIES(a_scale_in_scale, scale_done, state_ff == ST_SCALE, "scaling done out of turn")

endmodule
`default_nettype wire
